/* sv/cmsf_pkg.sv */
package cmsf_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int MAX_EDGES   = 4096;
   localparam int WEIGHT_BITS = 20;
   localparam int NODE_W      = 11;
   localparam int CNT_W       = 13;
   localparam int EIDX_W      = 12;
   localparam int LO_W        = 15;
   localparam int TOTAL_W     = 32;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_BUDGET     = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0]      a;
      logic [NODE_W-1:0]      b;
      logic [WEIGHT_BITS-1:0] w;
   } edge_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_FA_RD, ST_FA_CHK, ST_FB_RD, ST_FB_CHK,
      ST_UNION, ST_SORT, ST_PASS, ST_BLK, ST_MRD, ST_MWR, ST_KR_RD, ST_KR_LD,
      ST_KR_UN, ST_CHKB, ST_C_RD, ST_C_CHK, ST_FP_RD, ST_FP_AD, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_CHECK, CMD_FA_CHK, CMD_FB_CHK,
      CMD_UNION, CMD_SORT, CMD_PASS, CMD_BLK, CMD_MRD, CMD_MWR, CMD_KR_LD,
      CMD_KR_UN, CMD_CHKB, CMD_C_CHK, CMD_FP_AD, CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic edge_ok;
      logic costed;
      logic last;
      logic find_hit;
      logic pass_more;
      logic blk_more;
      logic mg_done;
      logic kr_more;
      logic over_budget;
      logic c_last;
      logic c_bad;
      logic fp_more;
   } status_type;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                  input logic [WEIGHT_BITS-1:0] w);
      logic [TOTAL_W:0] s;
      s = {1'b0, t} + {{(TOTAL_W+1-WEIGHT_BITS){1'b0}}, w};
      return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
   endfunction

endpackage

/* sv/cmsf_ctrl.sv */
module cmsf_ctrl
   import cmsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       strobe
);

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd = CMD_CHECK;
            if (status.edge_ok && !status.costed) state_in = ST_FA_RD;
            else if (status.last)                 state_in = ST_SORT;
            else                                  state_in = ST_IDLE;
         end
         ST_FA_RD: state_in = ST_FA_CHK;
         ST_FA_CHK: begin
            cmd      = CMD_FA_CHK;
            state_in = status.find_hit ? ST_FB_RD : ST_FA_RD;
         end
         ST_FB_RD: state_in = ST_FB_CHK;
         ST_FB_CHK: begin
            cmd = CMD_FB_CHK;
            if (!status.find_hit) state_in = ST_FB_RD;
            else if (fin_ff)      state_in = ST_KR_UN;
            else                  state_in = ST_UNION;
         end
         ST_UNION: begin
            cmd      = CMD_UNION;
            state_in = status.last ? ST_SORT : ST_IDLE;
         end
         ST_SORT: begin
            cmd      = CMD_SORT;
            fin_in   = 1'b1;
            state_in = ST_PASS;
         end
         ST_PASS: begin
            cmd      = CMD_PASS;
            state_in = status.pass_more ? ST_BLK : ST_KR_RD;
         end
         ST_BLK: begin
            cmd      = CMD_BLK;
            state_in = status.blk_more ? ST_MRD : ST_PASS;
         end
         ST_MRD: begin
            cmd      = CMD_MRD;
            state_in = status.mg_done ? ST_BLK : ST_MWR;
         end
         ST_MWR: begin
            cmd      = CMD_MWR;
            state_in = ST_MRD;
         end
         ST_KR_RD: state_in = status.kr_more ? ST_KR_LD : ST_CHKB;
         ST_KR_LD: begin
            cmd      = CMD_KR_LD;
            state_in = ST_FA_RD;
         end
         ST_KR_UN: begin
            cmd      = CMD_KR_UN;
            state_in = ST_KR_RD;
         end
         ST_CHKB: begin
            cmd      = CMD_CHKB;
            state_in = status.over_budget ? ST_OUT : ST_C_RD;
         end
         ST_C_RD: state_in = ST_C_CHK;
         ST_C_CHK: begin
            cmd = CMD_C_CHK;
            if (!status.find_hit)  state_in = ST_C_RD;
            else if (status.c_bad) state_in = ST_OUT;
            else if (status.c_last) state_in = ST_FP_RD;
            else                   state_in = ST_C_RD;
         end
         ST_FP_RD: state_in = status.fp_more ? ST_FP_AD : ST_OUT;
         ST_FP_AD: begin
            cmd      = CMD_FP_AD;
            state_in = ST_FP_RD;
         end
         ST_OUT: begin
            cmd      = CMD_OUT;
            fin_in   = 1'b0;
            state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = (state_ff == ST_OUT);

endmodule

/* sv/cmsf_dp.sv */
module cmsf_dp
   import cmsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CNT_W-1:0]       csr_wdata,
   input  logic [NODE_W-1:0]      end_a,
   input  logic [NODE_W-1:0]      end_b,
   input  logic [WEIGHT_BITS-1:0] weight,
   input  logic                   is_costed,
   input  logic                   last_edge,
   output status_type             status,
   output logic [TOTAL_W-1:0]     total_weight,
   output logic                   feasible
);

   logic [NODE_W-1:0] par_mem [0:MAX_NODES];
   edge_type          st0_mem [0:MAX_EDGES-1];
   edge_type          st1_mem [0:MAX_EDGES-1];
   logic              used_mem [0:MAX_EDGES-1];

   logic [NODE_W-1:0]      node_cnt_ff, node_cnt_in;
   logic [CNT_W-1:0]       budget_ff, budget_in;
   logic [NODE_W-1:0]      ea_ff, ea_in, eb_ff, eb_in;
   logic [WEIGHT_BITS-1:0] ew_ff, ew_in;
   logic                   costed_ff, costed_in, last_ff, last_in;
   logic [NODE_W-1:0]      x_ff, x_in, ra_ff, ra_in, rb_ff, rb_in, r1_ff, r1_in;
   logic [NODE_W-1:0]      ci_ff, ci_in, clr_ff, clr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, taken_ff, taken_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic                   ok_ff, ok_in, sel_ff, sel_in;
   logic [CNT_W-1:0]       wid_ff, wid_in;
   logic [LO_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]       mid_ff, mid_in, hi_ff, hi_in;
   logic [CNT_W-1:0]       i_ff, i_in, j_ff, j_in, k_ff, k_in, ki_ff, ki_in;

   logic [NODE_W-1:0] par_q;
   edge_type          s0a_q, s0b_q, s1a_q, s1b_q, qa, qb;
   logic              used_q;

   logic [NODE_W-1:0] nn;
   logic              full, take_j, par_we, st0_we, st1_we, diff;
   logic [NODE_W-1:0] par_wa, par_wd;
   logic [EIDX_W-1:0] rd_a, st0_wa;
   edge_type          st0_wd, mg_wd;
   logic [LO_W-1:0]   lo_mid, lo_hi, cnt_x;

   // effective node count, saturated to 1..MAX_NODES
   always_comb begin
      if (node_cnt_ff == '0)                           nn = NODE_W'(1);
      else if (node_cnt_ff > NODE_W'(MAX_NODES))       nn = NODE_W'(MAX_NODES);
      else                                             nn = node_cnt_ff;
   end

   assign qa     = sel_ff ? s1a_q : s0a_q;
   assign qb     = sel_ff ? s1b_q : s0b_q;
   assign full   = (cnt_ff == CNT_W'(MAX_EDGES));
   assign diff   = (ra_ff != rb_ff);
   assign take_j = (j_ff < hi_ff) && ((i_ff >= mid_ff) || (qb.w > qa.w));
   assign mg_wd  = take_j ? qb : qa;
   assign cnt_x  = LO_W'(cnt_ff);
   assign lo_mid = lo_ff + LO_W'(wid_ff);
   assign lo_hi  = lo_ff + LO_W'({wid_ff, 1'b0});
   assign rd_a   = (cmd == CMD_MRD) ? i_ff[EIDX_W-1:0] : ki_ff[EIDX_W-1:0];

   always_comb begin
      status.clr_done    = (clr_ff == NODE_W'(MAX_NODES));
      status.edge_ok     = (ea_ff != '0) && (eb_ff != '0) && (ea_ff <= nn) && (eb_ff <= nn);
      status.costed      = costed_ff;
      status.last        = last_ff;
      status.find_hit    = (par_q == x_ff);
      status.pass_more   = (wid_ff < cnt_ff);
      status.blk_more    = (lo_ff < cnt_x);
      status.mg_done     = (i_ff >= mid_ff) && (j_ff >= hi_ff);
      status.kr_more     = (ki_ff < cnt_ff);
      status.over_budget = (taken_ff > budget_ff);
      status.c_last      = (ci_ff == nn);
      status.c_bad       = (ci_ff != NODE_W'(1)) && (x_ff != r1_ff);
      status.fp_more     = (ki_ff < cnt_ff) && (taken_ff < budget_ff);
   end

   always_comb begin
      node_cnt_in = node_cnt_ff;
      budget_in   = budget_ff;
      ea_in = ea_ff;  eb_in = eb_ff;  ew_in = ew_ff;
      costed_in = costed_ff;  last_in = last_ff;
      x_in = x_ff;  ra_in = ra_ff;  rb_in = rb_ff;  r1_in = r1_ff;
      ci_in = ci_ff;  clr_in = clr_ff;
      cnt_in = cnt_ff;  taken_in = taken_ff;  total_in = total_ff;
      ok_in = ok_ff;  sel_in = sel_ff;
      wid_in = wid_ff;  lo_in = lo_ff;  mid_in = mid_ff;  hi_in = hi_ff;
      i_in = i_ff;  j_in = j_ff;  k_in = k_ff;  ki_in = ki_ff;
      par_we = 1'b0;  par_wa = ra_ff;  par_wd = rb_ff;
      st0_we = 1'b0;  st1_we = 1'b0;
      st0_wa = k_ff[EIDX_W-1:0];  st0_wd = mg_wd;

      if (csr_we) begin
         if (csr_index == CSR_NODE_COUNT) node_cnt_in = csr_wdata[NODE_W-1:0];
         else                             budget_in   = csr_wdata;
      end

      unique case (cmd)
         CMD_NONE: ;
         CMD_CLEAR: begin
            par_we = 1'b1;
            par_wa = clr_ff;
            par_wd = clr_ff;
            clr_in = clr_ff + NODE_W'(1);
         end
         CMD_LOAD: begin
            ea_in = end_a;  eb_in = end_b;  ew_in = weight;
            costed_in = is_costed;  last_in = last_edge;
         end
         CMD_CHECK: begin
            if (status.edge_ok && !costed_ff) x_in = ea_ff;
            if (status.edge_ok && costed_ff && !full) begin
               st0_we = 1'b1;
               st0_wa = cnt_ff[EIDX_W-1:0];
               st0_wd = '{a: ea_ff, b: eb_ff, w: ew_ff};
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         CMD_FA_CHK: begin
            if (status.find_hit) begin
               ra_in = x_ff;
               x_in  = eb_ff;
            end else x_in = par_q;
         end
         CMD_FB_CHK: begin
            if (status.find_hit) rb_in = x_ff;
            else                 x_in  = par_q;
         end
         CMD_UNION: begin
            par_we   = 1'b1;
            total_in = sat_add(total_ff, ew_ff);
         end
         CMD_SORT: wid_in = CNT_W'(1);
         CMD_PASS: begin
            lo_in = '0;
            ki_in = '0;
         end
         CMD_BLK: begin
            if (status.blk_more) begin
               mid_in = (lo_mid < cnt_x) ? lo_mid[CNT_W-1:0] : cnt_ff;
               hi_in  = (lo_hi < cnt_x) ? lo_hi[CNT_W-1:0] : cnt_ff;
               i_in   = lo_ff[CNT_W-1:0];
               j_in   = (lo_mid < cnt_x) ? lo_mid[CNT_W-1:0] : cnt_ff;
               k_in   = lo_ff[CNT_W-1:0];
            end else begin
               sel_in = ~sel_ff;
               wid_in = {wid_ff[CNT_W-2:0], 1'b0};
            end
         end
         CMD_MRD: if (status.mg_done) lo_in = lo_hi;
         CMD_MWR: begin
            st0_we = sel_ff;
            st1_we = ~sel_ff;
            k_in   = k_ff + CNT_W'(1);
            if (take_j) j_in = j_ff + CNT_W'(1);
            else        i_in = i_ff + CNT_W'(1);
         end
         CMD_KR_LD: begin
            ea_in = qa.a;  eb_in = qa.b;  ew_in = qa.w;
            x_in  = qa.a;
         end
         CMD_KR_UN: begin
            if (diff) begin
               par_we   = 1'b1;
               taken_in = taken_ff + CNT_W'(1);
               total_in = sat_add(total_ff, ew_ff);
            end
            ki_in = ki_ff + CNT_W'(1);
         end
         CMD_CHKB: begin
            if (status.over_budget) ok_in = 1'b0;
            x_in  = NODE_W'(1);
            ci_in = NODE_W'(1);
         end
         CMD_C_CHK: begin
            if (status.find_hit) begin
               if (status.c_bad) ok_in = 1'b0;
               if (ci_ff == NODE_W'(1)) r1_in = x_ff;
               ci_in = ci_ff + NODE_W'(1);
               x_in  = ci_ff + NODE_W'(1);
               ki_in = '0;
            end else x_in = par_q;
         end
         CMD_FP_AD: begin
            if (!used_q) begin
               taken_in = taken_ff + CNT_W'(1);
               total_in = sat_add(total_ff, qa.w);
            end
            ki_in = ki_ff + CNT_W'(1);
         end
         CMD_OUT: begin
            cnt_in = '0;  taken_in = '0;  total_in = '0;
            ok_in  = 1'b1;  sel_in = 1'b0;  clr_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_cnt_ff <= NODE_W'(1);
         budget_ff   <= '0;
         cnt_ff      <= '0;
         taken_ff    <= '0;
         total_ff    <= '0;
         ok_ff       <= 1'b1;
         sel_ff      <= 1'b0;
         clr_ff      <= '0;
      end else begin
         node_cnt_ff <= node_cnt_in;
         budget_ff   <= budget_in;
         cnt_ff      <= cnt_in;
         taken_ff    <= taken_in;
         total_ff    <= total_in;
         ok_ff       <= ok_in;
         sel_ff      <= sel_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      ea_ff <= ea_in;  eb_ff <= eb_in;  ew_ff <= ew_in;
      costed_ff <= costed_in;  last_ff <= last_in;
      x_ff <= x_in;  ra_ff <= ra_in;  rb_ff <= rb_in;  r1_ff <= r1_in;
      ci_ff <= ci_in;
      wid_ff <= wid_in;  lo_ff <= lo_in;  mid_ff <= mid_in;  hi_ff <= hi_in;
      i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;  ki_ff <= ki_in;
   end

   // union-find parent store
   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_q <= par_mem[x_ff];
   end

   // costed edge stores, ping-pong for the merge passes
   always_ff @(posedge clock) begin
      if (st0_we) st0_mem[st0_wa] <= st0_wd;
      s0a_q <= st0_mem[rd_a];
      s0b_q <= st0_mem[j_ff[EIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (st1_we) st1_mem[k_ff[EIDX_W-1:0]] <= mg_wd;
      s1a_q <= st1_mem[rd_a];
      s1b_q <= st1_mem[j_ff[EIDX_W-1:0]];
   end

   // used marks, every entry below the count is written in the kruskal pass
   always_ff @(posedge clock) begin
      if (cmd == CMD_KR_UN) used_mem[ki_ff[EIDX_W-1:0]] <= diff;
      used_q <= used_mem[ki_ff[EIDX_W-1:0]];
   end

   assign total_weight = ok_ff ? total_ff : '0;
   assign feasible     = ok_ff;

endmodule

/* sv/constrained_max_spanning_forest_top.sv */
// channel   | ports                                             | beat taken when
// ----------+---------------------------------------------------+---------------------------
// request   | start, busy, req_end_a/end_b/weight/is_costed/... | start && !busy
// response  | rsp_strobe, rsp_total_weight, rsp_feasible        | rsp_strobe (one cycle)
// csr write | csr_valid, csr_ready, csr_index, csr_wdata        | csr_valid && csr_ready
//
// a costed or dropped edge ends in the check state; a free edge adds two finds, a read and a
// check state per union-find hop, and a union; the last edge starts the finish: merge sort
// passes, a read and a write state per element, a kruskal pass with two finds per costed
// edge, one find per node for the connectivity check, and a top-up pass; the parent store's
// single read port sets the find rate; after reset and after every result a clearing pass
// rewrites the 1025 parent entries with busy high; csr writes are taken at any time
// the receiver cannot stall: rsp_strobe is high for exactly one cycle
module constrained_max_spanning_forest_top
   import cmsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request beat
   input  logic                   start,
   output logic                   busy,
   input  logic [NODE_W-1:0]      req_end_a,
   input  logic [NODE_W-1:0]      req_end_b,
   input  logic [WEIGHT_BITS-1:0] req_weight,
   input  logic                   req_is_costed,
   input  logic                   req_last_edge,
   // response beat
   output logic                   rsp_strobe,
   output logic [TOTAL_W-1:0]     rsp_total_weight,
   output logic                   rsp_feasible,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CNT_W-1:0]       csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   // sequencer: walks load, sort, kruskal, check, top-up and clear phases
   cmsf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   // stores, counters and compare logic
   cmsf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .end_a        (req_end_a),
      .end_b        (req_end_b),
      .weight       (req_weight),
      .is_costed    (req_is_costed),
      .last_edge    (req_last_edge),
      .status       (status),
      .total_weight (rsp_total_weight),
      .feasible     (rsp_feasible)
   );

   // a result only shows while the block is working on a graph
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result strobe while idle");

   // an infeasible answer reports a zero total
   a_infeasible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_feasible |-> rsp_total_weight == '0)
      else $error("infeasible result with nonzero total");

   // an accepted edge keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted edge left block idle");

   // the clearing pass follows a result, so no two strobes in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");

endmodule

/* tb/constrained_max_spanning_forest_top_test.sv */
`timescale 1ns / 100ps

module constrained_max_spanning_forest_top_test;
   import cmsf_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   // one answer of the block
   typedef struct {
      logic [TOTAL_W-1:0] total;
      logic               feasible;
   } answer_type;

   // one row of the directed plan: either a register write or an edge
   typedef enum {ROW_CSR, ROW_EDGE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic                   reg_index;
      logic [CNT_W-1:0]       reg_value;
      logic [NODE_W-1:0]      a;
      logic [NODE_W-1:0]      b;
      logic [WEIGHT_BITS-1:0] w;
      logic                   costed;
      logic                   last;
      bit                     typed;
      logic [TOTAL_W-1:0]     typed_total;
      logic                   typed_feasible;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [NODE_W-1:0]      req_end_a;
   logic [NODE_W-1:0]      req_end_b;
   logic [WEIGHT_BITS-1:0] req_weight;
   logic                   req_is_costed;
   logic                   req_last_edge;
   logic                   rsp_strobe;
   logic [TOTAL_W-1:0]     rsp_total_weight;
   logic                   rsp_feasible;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_index;
   logic [CNT_W-1:0]       csr_wdata;

   constrained_max_spanning_forest_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_end_a        (req_end_a),
      .req_end_b        (req_end_b),
      .req_weight       (req_weight),
      .req_is_costed    (req_is_costed),
      .req_last_edge    (req_last_edge),
      .rsp_strobe       (rsp_strobe),
      .rsp_total_weight (rsp_total_weight),
      .rsp_feasible     (rsp_feasible),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // free-running clock, 8 ns period
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // forest predictor: own copy of registers and graph state
   // ---------------------------------------------------------------
   logic [NODE_W-1:0]      node_reg;
   logic [CNT_W-1:0]       budget_reg;
   logic [NODE_W-1:0]      link [0:MAX_NODES];
   edge_type               kept_edges [0:MAX_EDGES-1];
   bit                     kept_used [0:MAX_EDGES-1];
   int unsigned            kept_count;
   int unsigned            picked_count;
   logic [TOTAL_W-1:0]     forest_sum;

   answer_type             pending_answers [$];

   int unsigned            idle_pct;
   int unsigned            edges_sent;
   int unsigned            graphs_done;
   int unsigned            feasible_seen;
   int unsigned            csr_writes;
   int unsigned            mismatches;
   int unsigned            cycle_count;

   function automatic void clear_forest();
      for (int i = 0; i <= MAX_NODES; i++) link[i] = NODE_W'(i);
      for (int i = 0; i < MAX_EDGES; i++) kept_used[i] = 1'b0;
      kept_count   = 0;
      picked_count = 0;
      forest_sum   = '0;
   endfunction

   function automatic int unsigned live_nodes();
      if (node_reg < 1) return 1;
      if (node_reg > MAX_NODES) return MAX_NODES;
      return node_reg;
   endfunction

   function automatic logic [NODE_W-1:0] root_node(input logic [NODE_W-1:0] x);
      logic [NODE_W-1:0] r;
      r = x;
      while (link[r] != r) r = link[r];
      return r;
   endfunction

   function automatic void grow_sum(input logic [WEIGHT_BITS-1:0] w);
      logic [TOTAL_W:0] s;
      s = {1'b0, forest_sum} + (TOTAL_W+1)'(w);
      forest_sum = s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
   endfunction

   // stable sort, heaviest first
   function automatic void order_kept();
      edge_type key;
      int       j;
      for (int i = 1; i < kept_count; i++) begin
         key = kept_edges[i];
         j   = i - 1;
         while (j >= 0 && kept_edges[j].w < key.w) begin
            kept_edges[j+1] = kept_edges[j];
            j--;
         end
         kept_edges[j+1] = key;
      end
   endfunction

   function automatic answer_type solve_forest();
      answer_type        ans;
      logic [NODE_W-1:0] ra, rb;
      bit                ok;
      int unsigned       nn;
      nn = live_nodes();
      ok = 1'b1;
      order_kept();
      // kruskal over the costed edges
      for (int i = 0; i < kept_count; i++) begin
         ra = root_node(kept_edges[i].a);
         rb = root_node(kept_edges[i].b);
         if (ra != rb) begin
            link[ra] = rb;
            picked_count++;
            grow_sum(kept_edges[i].w);
            kept_used[i] = 1'b1;
         end
      end
      if (picked_count > budget_reg) ok = 1'b0;
      for (int i = 1; ok && i < nn; i++)
         if (root_node(NODE_W'(i)) != root_node(NODE_W'(i + 1))) ok = 1'b0;
      // top up with the heaviest unused edges until the budget is met
      if (ok)
         for (int i = 0; i < kept_count && picked_count < budget_reg; i++)
            if (!kept_used[i]) begin
               grow_sum(kept_edges[i].w);
               picked_count++;
            end
      ans.total    = ok ? forest_sum : '0;
      ans.feasible = ok;
      clear_forest();
      return ans;
   endfunction

   // returns 1 when the edge closes the graph and an answer is due
   function automatic bit take_edge(input logic [NODE_W-1:0] a, b,
                                    input logic [WEIGHT_BITS-1:0] w,
                                    input logic costed, last, output answer_type ans);
      int unsigned nn;
      nn = live_nodes();
      if (a >= 1 && b >= 1 && a <= nn && b <= nn) begin
         if (!costed) begin
            link[root_node(a)] = root_node(b);
            grow_sum(w);
         end else if (kept_count < MAX_EDGES) begin
            kept_edges[kept_count] = '{a: a, b: b, w: w};
            kept_count++;
         end
      end
      if (!last) return 1'b0;
      ans = solve_forest();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // drivers: inputs change on the falling edge
   // ---------------------------------------------------------------
   task automatic write_reg(input logic idx, input logic [CNT_W-1:0] value);
      @(negedge clock);
      start     = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_NODE_COUNT) node_reg = value[NODE_W-1:0];
      else budget_reg = value;
      csr_writes++;
   endtask

   // one edge beat; start is left high so back-to-back beats need no gap
   task automatic send_edge(input logic [NODE_W-1:0] a, b, input logic [WEIGHT_BITS-1:0] w,
                            input logic costed, last, input bit typed,
                            input logic [TOTAL_W-1:0] t_total, input logic t_feasible);
      answer_type ans;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start         = 1'b1;
      req_end_a     = a;
      req_end_b     = b;
      req_weight    = w;
      req_is_costed = costed;
      req_last_edge = last;
      do @(posedge clock); while (busy);
      edges_sent++;
      if (take_edge(a, b, w, costed, last, ans)) begin
         if (typed) begin
            ans.total    = t_total;
            ans.feasible = t_feasible;
         end
         pending_answers.push_back(ans);
         graphs_done++;
         // drop start before anything else can happen on the next edge
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // response checker: outputs sampled on the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: total %0d feasible %0b",
                        rsp_total_weight, rsp_feasible);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_feasible) feasible_seen++;
            if (rsp_total_weight !== want.total || rsp_feasible !== want.feasible) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected total %0d feasible %0b, got %0d %0b",
                           want.total, want.feasible, rsp_total_weight, rsp_feasible);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", pending_answers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // random graphs
   // ---------------------------------------------------------------
   task automatic random_graph();
      int unsigned nn, n_extra, wild;
      logic [NODE_W-1:0] a, b;
      // pick a new setting now and then, always between graphs
      wait (pending_answers.size() == 0);
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(9))
            0: write_reg(CSR_NODE_COUNT, CNT_W'($urandom_range(2047)));
            1: write_reg(CSR_NODE_COUNT, 13'd1);
            default: write_reg(CSR_NODE_COUNT, CNT_W'($urandom_range(12, 2)));
         endcase
      end
      if ($urandom_range(2) == 0) begin
         if ($urandom_range(15) == 0) write_reg(CSR_BUDGET, 13'h1FFF);
         else write_reg(CSR_BUDGET, CNT_W'($urandom_range(6)));
      end
      nn      = live_nodes();
      wild    = ($urandom_range(9) == 0);
      n_extra = $urandom_range(6);
      // mostly a spanning tree with random extras, sometimes pure noise
      if (!wild && nn <= 16)
         for (int i = 2; i <= nn; i++) begin
            a = NODE_W'(i);
            b = NODE_W'($urandom_range(i - 1, 1));
            if ($urandom_range(1)) {a, b} = {b, a};
            send_edge(a, b, WEIGHT_BITS'($urandom), 1'($urandom_range(1)), 1'b0, 0, '0,
                      1'b0);
         end
      for (int i = 0; i < n_extra; i++) begin
         if (wild || $urandom_range(7) == 0) begin
            a = NODE_W'($urandom);
            b = NODE_W'($urandom);
         end else begin
            a = NODE_W'($urandom_range(nn < 16 ? nn : 16, 1));
            b = NODE_W'($urandom_range(nn < 16 ? nn : 16, 1));
         end
         send_edge(a, b, WEIGHT_BITS'($urandom), 1'($urandom_range(1)), 1'b0, 0, '0, 1'b0);
      end
      send_edge(NODE_W'($urandom_range(nn < 16 ? nn : 16, 1)),
                NODE_W'($urandom_range(nn < 16 ? nn : 16, 1)),
                WEIGHT_BITS'($urandom), 1'($urandom_range(1)), 1'b1, 0, '0, 1'b0);
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      plan_row_type plan [$];
      int unsigned  phase_pct [4];
      int unsigned  phase_goal;

      start         = 1'b0;
      req_end_a     = '0;
      req_end_b     = '0;
      req_weight    = '0;
      req_is_costed = 1'b0;
      req_last_edge = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_NODE_COUNT;
      csr_wdata     = '0;
      idle_pct      = 0;
      edges_sent    = 0;
      graphs_done   = 0;
      feasible_seen = 0;
      csr_writes    = 0;
      mismatches    = 0;
      cycle_count   = 0;
      node_reg      = 1;
      budget_reg    = 0;
      clear_forest();

      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed plan; typed answers only where they are obvious
      plan = '{
         // reset settings: one node, no budget; self loop closes the graph
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 1, 5, 0, 1, 1, 5, 1},
         // zero endpoint dropped, a lone node is still connected
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 0, 1, 7, 0, 1, 1, 0, 1},
         '{ROW_CSR, CSR_NODE_COUNT, 3, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, CSR_BUDGET, 1, 0, 0, 0, 0, 0, 0, 0, 0},
         // free edge plus two costed, kruskal keeps the heavier
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 10, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 2, 3, 20, 1, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 3, 30, 1, 1, 0, 0, 0},
         // node 3 left alone: infeasible answer with a zero total
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 9, 0, 1, 1, 0, 0},
         // two costed edges needed but budget zero
         '{ROW_CSR, CSR_BUDGET, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 1, 1, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 2, 3, 2, 1, 1, 1, 0, 0},
         // endpoints past the node count are dropped, max weights kept
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 4, 1, 99, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 2047, 2047, 99, 1, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 1048575, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 2, 3, 1048575, 0, 1, 1, 2097150, 1},
         // node count zero behaves as one
         '{ROW_CSR, CSR_NODE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 1, 0, 1, 1, 0, 0, 0},
         // budget beyond the available edges: top-up runs dry
         '{ROW_CSR, CSR_NODE_COUNT, 2, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_CSR, CSR_BUDGET, 13'h1FFF, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 3, 1, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1, 2, 4, 1, 1, 0, 0, 0},
         // largest node count, far from connected
         '{ROW_CSR, CSR_NODE_COUNT, 1024, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1024, 1023, 1048575, 1, 1, 1, 0, 0},
         // node count above the maximum saturates
         '{ROW_CSR, CSR_NODE_COUNT, 2047, 0, 0, 0, 0, 0, 0, 0, 0},
         '{ROW_EDGE, CSR_NODE_COUNT, 0, 1024, 1, 5, 0, 1, 1, 0, 0}
      };

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait (pending_answers.size() == 0);
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            send_edge(plan[i].a, plan[i].b, plan[i].w, plan[i].costed, plan[i].last,
                      plan[i].typed, plan[i].typed_total, plan[i].typed_feasible);
         end
      end

      // random part in phases of sender idling; the receiver never stalls
      phase_pct = '{0, 80, 17, 0};
      foreach (phase_pct[p]) begin
         idle_pct   = phase_pct[p];
         phase_goal = edges_sent + 400;
         while (edges_sent < phase_goal) random_graph();
      end

      // drain: wait for the last answers, then idle before the summary
      wait (pending_answers.size() == 0);
      repeat (200) @(posedge clock);

      $display("covered %0d edges in %0d graphs (%0d feasible), %0d register writes",
               edges_sent, graphs_done, feasible_seen, csr_writes);
      $display("phases ran with sender idle at 0, 80 and 17 percent; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
